// File: sv/bthin_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bthin_pkg - shared types and constants for the thinning block
// Request payloads, action and register codes, controller states and the
// neighbor offset table used by the scan.
// ----------------------------------------------------------------------------
package bthin_pkg;

  localparam int MAX_WIDTH_DEF  = 256;
  localparam int MAX_HEIGHT_DEF = 256;
  localparam int CFG_W          = 16;
  localparam int CFG_IDX_W      = 2;
  localparam int SIZE_W         = 9;
  localparam int CNT_W          = 16;
  localparam int MIN_SET        = 2;
  localparam int MAX_SET        = 6;
  localparam int NBR_LAST       = 9;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_RUN   = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WIDTH  = 2'd0,
    REG_HEIGHT = 2'd1,
    REG_LIMIT  = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] row;
    logic [7:0] col;
    logic       pixel_in;
  } in_item_t;

  typedef struct packed {
    logic             pixel_out;
    logic [CNT_W-1:0] passes_run;
  } out_item_t;

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_READ     = 8'b0000_0010,
    ST_ITER     = 8'b0000_0100,
    ST_SCAN     = 8'b0000_1000,
    ST_EVAL     = 8'b0001_0000,
    ST_APPLY_RD = 8'b0010_0000,
    ST_APPLY_WR = 8'b0100_0000,
    ST_FIN      = 8'b1000_0000
  } state_t;

  // neighbor window sample and the pass it is tested under
  typedef struct packed {
    logic [7:0] nbr;
    logic       second;
  } win_t;

  typedef struct packed {
    logic signed [1:0] dr;
    logic signed [1:0] dc;
  } offs_t;

  // slot 0 is the center, slots 1..8 are p2..p9 clockwise from north
  function automatic offs_t nbr_offset(input logic [3:0] k);
    offs_t o;
    case (k)
      4'd1:    o = '{dr: -2'sd1, dc:  2'sd0};
      4'd2:    o = '{dr: -2'sd1, dc:  2'sd1};
      4'd3:    o = '{dr:  2'sd0, dc:  2'sd1};
      4'd4:    o = '{dr:  2'sd1, dc:  2'sd1};
      4'd5:    o = '{dr:  2'sd1, dc:  2'sd0};
      4'd6:    o = '{dr:  2'sd1, dc: -2'sd1};
      4'd7:    o = '{dr:  2'sd0, dc: -2'sd1};
      4'd8:    o = '{dr: -2'sd1, dc: -2'sd1};
      default: o = '{dr:  2'sd0, dc:  2'sd0};
    endcase
    return o;
  endfunction

endpackage
`default_nettype wire

// File: sv/bthin_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bthin_ram - one-bit synchronous memory
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bthin_ram #(
  parameter int DEPTH = 65536,
  parameter int AW    = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic          wdata,
  input  wire logic [AW-1:0] raddr,
  output logic               rdata
);

  logic mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: sv/bthin_eval.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bthin_eval - Zhang-Suen deletion test
// Decides from the eight neighbors whether a set pixel is removed.
// ----------------------------------------------------------------------------
module bthin_eval (
  input  wire bthin_pkg::win_t win,
  output logic                 del
);

  logic [3:0] sum;
  logic [3:0] trans;
  logic [7:0] n;
  logic       prod_ok;

  assign n = win.nbr;

  always_comb begin
    sum   = '0;
    trans = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + 4'(n[i]);
      if (!n[i] && n[(i + 1) % 8]) begin
        trans = trans + 4'd1;
      end
    end
    if (!win.second) begin
      prod_ok = !(n[0] & n[2] & n[4]) && !(n[2] & n[4] & n[6]);
    end else begin
      prod_ok = !(n[0] & n[2] & n[6]) && !(n[0] & n[4] & n[6]);
    end
    del = (sum >= 4'(bthin_pkg::MIN_SET)) && (sum <= 4'(bthin_pkg::MAX_SET)) &&
          (trans == 4'd1) && prod_ok;
  end

endmodule
`default_nettype wire

// File: sv/binary_image_thinning.sv
`default_nettype none
// Write request: stored on acceptance. Read request: one memory read.
// Run request: per sub-pass the 3x3 window of each active pixel is gathered
// through the single image read port, then the marks are applied pixel by
// pixel; each iteration passes through ST_ITER and the run ends in ST_FIN.
// Reset clears configuration (256 x 256, no limit) and control; the image
// and mark memories are undefined until written.
// ----------------------------------------------------------------------------
// binary_image_thinning - pixel store with Zhang-Suen skeletonization
// Holds a one-bit image in memory; requests write, read or thin it.
// ----------------------------------------------------------------------------
module binary_image_thinning #(
  parameter int MAX_WIDTH  = bthin_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = bthin_pkg::MAX_HEIGHT_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire bthin_pkg::in_item_t              in_data,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output bthin_pkg::out_item_t                  out_data,
  input  wire logic                             cfg_we,
  input  wire logic [bthin_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [bthin_pkg::CFG_W-1:0]      cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int HW    = $clog2(MAX_HEIGHT + 1);
  localparam int WW    = $clog2(MAX_WIDTH + 1);
  localparam int SW    = bthin_pkg::SIZE_W;
  localparam int NW    = bthin_pkg::CNT_W;

  bthin_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] width_r, height_r;
  logic [NW-1:0] limit_r;
  logic [HW-1:0] h_r, h_nxt, h_clamp;
  logic [WW-1:0] w_r, w_nxt, w_clamp;
  logic [RW-1:0] r_r, r_nxt;
  logic [CW-1:0] c_r, c_nxt;
  logic [3:0]    k_r, k_nxt;
  logic [7:0]    nbr_r, nbr_nxt;
  logic          ctr_r, ctr_nxt;
  logic          vld_r, vld_nxt;
  logic          second_r, second_nxt;
  logic          any_r, any_nxt;
  logic          rd_in_r, rd_in_nxt;
  logic [NW:0]   count_r, count_nxt;
  logic [NW-1:0] passes_r, passes_nxt;
  logic          out_valid_r, out_valid_nxt;
  bthin_pkg::out_item_t out_r, out_nxt;

  logic          accept;
  logic          u_inside;
  logic [AW-1:0] u_addr, ctr_addr, scan_addr;
  bthin_pkg::offs_t off;
  logic signed [RW+1:0] nr;
  logic signed [CW+1:0] nc;
  logic          n_in;
  logic [RW-1:0] sel_r;
  logic [CW-1:0] sel_c;
  logic          last_c, last_r;

  logic          img_we, img_wdata, img_q;
  logic [AW-1:0] img_waddr, img_raddr;
  logic          mrk_we, mrk_q;
  logic          del;
  bthin_pkg::win_t win;

  assign in_ready  = (state_r == bthin_pkg::ST_IDLE) && (!out_valid_r || out_ready);
  assign accept    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= SW'(256);
      height_r <= SW'(256);
      limit_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bthin_pkg::REG_WIDTH:  width_r  <= cfg_data[SW-1:0];
        bthin_pkg::REG_HEIGHT: height_r <= cfg_data[SW-1:0];
        bthin_pkg::REG_LIMIT:  limit_r  <= cfg_data[NW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (height_r == '0) begin
      h_clamp = HW'(1);
    end else if (32'(height_r) > 32'(MAX_HEIGHT)) begin
      h_clamp = HW'(MAX_HEIGHT);
    end else begin
      h_clamp = HW'(height_r);
    end
    if (width_r == '0) begin
      w_clamp = WW'(1);
    end else if (32'(width_r) > 32'(MAX_WIDTH)) begin
      w_clamp = WW'(MAX_WIDTH);
    end else begin
      w_clamp = WW'(width_r);
    end
  end

  // addressing
  assign u_inside = (32'(in_data.row) < 32'(MAX_HEIGHT)) && (32'(in_data.col) < 32'(MAX_WIDTH));
  assign u_addr   = AW'(32'(in_data.row) * MAX_WIDTH + 32'(in_data.col));
  assign ctr_addr = AW'(32'(r_r) * MAX_WIDTH + 32'(c_r));

  assign off  = bthin_pkg::nbr_offset(k_r);
  assign nr   = $signed({2'b00, r_r}) + (RW+2)'(off.dr);
  assign nc   = $signed({2'b00, c_r}) + (CW+2)'(off.dc);
  assign n_in = (nr >= 0) && (nr < $signed((RW+2)'(h_r))) &&
                (nc >= 0) && (nc < $signed((CW+2)'(w_r)));
  assign sel_r     = n_in ? nr[RW-1:0] : r_r;
  assign sel_c     = n_in ? nc[CW-1:0] : c_r;
  assign scan_addr = AW'(32'(sel_r) * MAX_WIDTH + 32'(sel_c));

  assign last_c = (32'(c_r) + 1) == 32'(w_r);
  assign last_r = (32'(r_r) + 1) == 32'(h_r);

  assign img_raddr = (state_r == bthin_pkg::ST_IDLE) ? u_addr : scan_addr;
  assign img_we    = (accept && in_data.action == bthin_pkg::ACT_WRITE && u_inside) ||
                     (state_r == bthin_pkg::ST_APPLY_WR && mrk_q);
  assign img_waddr = (state_r == bthin_pkg::ST_IDLE) ? u_addr : ctr_addr;
  assign img_wdata = (state_r == bthin_pkg::ST_IDLE) ? in_data.pixel_in : 1'b0;

  assign win.nbr    = nbr_r;
  assign win.second = second_r;
  assign mrk_we     = (state_r == bthin_pkg::ST_EVAL);

  bthin_ram #(.DEPTH(DEPTH), .AW(AW)) u_img (
    .clk   (clk),
    .we    (img_we),
    .waddr (img_waddr),
    .wdata (img_wdata),
    .raddr (img_raddr),
    .rdata (img_q)
  );

  bthin_ram #(.DEPTH(DEPTH), .AW(AW)) u_mrk (
    .clk   (clk),
    .we    (mrk_we),
    .waddr (ctr_addr),
    .wdata (ctr_r && del),
    .raddr (ctr_addr),
    .rdata (mrk_q)
  );

  bthin_eval u_eval (
    .win (win),
    .del (del)
  );

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    r_nxt         = r_r;
    c_nxt         = c_r;
    k_nxt         = k_r;
    nbr_nxt       = nbr_r;
    ctr_nxt       = ctr_r;
    vld_nxt       = vld_r;
    second_nxt    = second_r;
    any_nxt       = any_r;
    rd_in_nxt     = rd_in_r;
    count_nxt     = count_r;
    passes_nxt    = passes_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;

    case (state_r)
      bthin_pkg::ST_IDLE: begin
        if (accept) begin
          case (in_data.action)
            bthin_pkg::ACT_READ: begin
              rd_in_nxt = u_inside;
              state_nxt = bthin_pkg::ST_READ;
            end
            bthin_pkg::ACT_RUN: begin
              h_nxt      = h_clamp;
              w_nxt      = w_clamp;
              count_nxt  = '0;
              passes_nxt = '0;
              state_nxt  = bthin_pkg::ST_ITER;
            end
            default: begin
              out_nxt       = '0;
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end

      bthin_pkg::ST_READ: begin
        out_nxt           = '0;
        out_nxt.pixel_out = rd_in_r && img_q;
        out_valid_nxt     = 1'b1;
        state_nxt         = bthin_pkg::ST_IDLE;
      end

      bthin_pkg::ST_ITER: begin
        count_nxt = (count_r == '1) ? count_r : count_r + 1'b1;
        if (limit_r != '0 && count_nxt > (NW+1)'(limit_r)) begin
          state_nxt = bthin_pkg::ST_FIN;
        end else begin
          passes_nxt = (passes_r == '1) ? passes_r : passes_r + 1'b1;
          second_nxt = 1'b0;
          any_nxt    = 1'b0;
          r_nxt      = '0;
          c_nxt      = '0;
          k_nxt      = '0;
          state_nxt  = bthin_pkg::ST_SCAN;
        end
      end

      bthin_pkg::ST_SCAN: begin
        // issue read of slot k, capture slot k-1 from the previous read
        vld_nxt = n_in;
        if (k_r != '0) begin
          if (k_r == 4'd1) begin
            ctr_nxt = img_q && vld_r;
          end
          for (int i = 0; i < 8; i++) begin
            if (32'(k_r) == i + 2) begin
              nbr_nxt[i] = img_q && vld_r;
            end
          end
        end
        if (k_r == 4'(bthin_pkg::NBR_LAST)) begin
          k_nxt     = '0;
          state_nxt = bthin_pkg::ST_EVAL;
        end else begin
          k_nxt = k_r + 4'd1;
        end
      end

      bthin_pkg::ST_EVAL: begin
        any_nxt = any_r || (ctr_r && del);
        if (last_c) begin
          c_nxt = '0;
          if (last_r) begin
            r_nxt     = '0;
            state_nxt = any_nxt ? bthin_pkg::ST_APPLY_RD : bthin_pkg::ST_FIN;
          end else begin
            r_nxt     = r_r + 1'b1;
            state_nxt = bthin_pkg::ST_SCAN;
          end
        end else begin
          c_nxt     = c_r + 1'b1;
          state_nxt = bthin_pkg::ST_SCAN;
        end
      end

      bthin_pkg::ST_APPLY_RD: begin
        state_nxt = bthin_pkg::ST_APPLY_WR;
      end

      bthin_pkg::ST_APPLY_WR: begin
        state_nxt = bthin_pkg::ST_APPLY_RD;
        if (last_c) begin
          c_nxt = '0;
          if (last_r) begin
            r_nxt = '0;
            if (!second_r) begin
              passes_nxt = (passes_r == '1) ? passes_r : passes_r + 1'b1;
              second_nxt = 1'b1;
              any_nxt    = 1'b0;
              k_nxt      = '0;
              state_nxt  = bthin_pkg::ST_SCAN;
            end else begin
              state_nxt = bthin_pkg::ST_ITER;
            end
          end else begin
            r_nxt = r_r + 1'b1;
          end
        end else begin
          c_nxt = c_r + 1'b1;
        end
      end

      bthin_pkg::ST_FIN: begin
        out_nxt            = '0;
        out_nxt.passes_run = passes_r;
        out_valid_nxt      = 1'b1;
        state_nxt          = bthin_pkg::ST_IDLE;
      end

      default: begin
        state_nxt = bthin_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bthin_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      k_r         <= '0;
      r_r         <= '0;
      c_r         <= '0;
      second_r    <= 1'b0;
      any_r       <= 1'b0;
      count_r     <= '0;
      passes_r    <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      r_r         <= r_nxt;
      c_r         <= c_nxt;
      second_r    <= second_nxt;
      any_r       <= any_nxt;
      count_r     <= count_nxt;
      passes_r    <= passes_nxt;
    end
  end

  always_ff @(posedge clk) begin
    h_r     <= h_nxt;
    w_r     <= w_nxt;
    nbr_r   <= nbr_nxt;
    ctr_r   <= ctr_nxt;
    vld_r   <= vld_nxt;
    rd_in_r <= rd_in_nxt;
    out_r   <= out_nxt;
  end

endmodule
`default_nettype wire
